### src/tcp_pkg.sv
// Shared types, constants and helper functions for the text cell placement block.
package tcp_pkg;

  typedef enum logic {
    ReqPlace  = 1'b0,
    ReqCursor = 1'b1
  } req_e;

  localparam int unsigned QueueDepthDef = 2;
  localparam int unsigned RunBytes      = 4;

  localparam logic [7:0]  SyncCommand   = 8'hF8;
  localparam logic [7:0]  SyncData      = 8'hFA;
  localparam logic [7:0]  SpaceByte     = 8'h20;
  localparam logic [15:0] HalfWidthMax  = 16'd128;
  localparam logic [7:0]  MappedHigh    = 8'hFF;

  // One queued run: up to four words, one command flag per word.
  typedef struct packed {
    logic [1:0]                last_idx;
    logic [RunBytes-1:0]       cmd;
    logic [RunBytes-1:0][7:0]  bytes;
  } run_t;

  // DDRAM address command for a packed {row, column} cursor.
  function automatic logic [7:0] addr_cmd(input logic [5:0] pos);
    logic [7:0] base;
    begin
      case (pos[5:4])
        2'd0:    base = 8'h80;
        2'd1:    base = 8'h90;
        2'd2:    base = 8'h88;
        default: base = 8'h98;
      endcase
      addr_cmd = base | {5'd0, pos[3:1]};
    end
  endfunction

  // Sync byte, high nibble, low nibble; each nibble in the upper half.
  function automatic logic [23:0] serial_frame(input logic is_cmd, input logic [7:0] b);
    logic [7:0] sync;
    begin
      sync = is_cmd ? SyncCommand : SyncData;
      serial_frame = {sync, b[7:4], 4'h0, b[3:0], 4'h0};
    end
  endfunction

endpackage

### src/tcp_if.sv
// Handshake channel interfaces for input items and output words.
interface tcp_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] char_code;
  logic [3:0]  cursor_column;
  logic [1:0]  cursor_row;

  modport source (output valid, req_type, char_code, cursor_column, cursor_row,
                  input ready);
  modport sink   (input valid, req_type, char_code, cursor_column, cursor_row,
                  output ready);
endinterface

interface tcp_out_if;
  logic        valid;
  logic        ready;
  logic        is_command;
  logic [7:0]  byte_value;
  logic [23:0] serial_frame;
  logic        last_of_run;

  modport source (output valid, is_command, byte_value, serial_frame, last_of_run,
                  input ready);
  modport sink   (input valid, is_command, byte_value, serial_frame, last_of_run,
                  output ready);
endinterface

### src/tcp_front.sv
// Front end: accepts items, keeps the cursor and held byte, builds word runs.
module tcp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  tcp_in_if.sink        in_i,
  input  logic          q_full_i,
  output logic          push_o,
  output tcp_pkg::run_t run_o
);

  logic [5:0] pos_q, pos_d;      // {row, column}
  logic [7:0] held_q, held_d;
  logic       accept;
  logic [15:0] code;
  logic [7:0]  lo_b;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && !q_full_i;
  assign push_o     = accept && (in_i.req_type == tcp_pkg::ReqPlace);

  // 0xFFxx codes map to 0xFFFF - code, which is the bitwise complement.
  assign code = (in_i.char_code[15:8] == tcp_pkg::MappedHigh) ? ~in_i.char_code
                                                              : in_i.char_code;
  assign lo_b = in_i.char_code[7:0];

  always_comb begin
    run_o  = '0;
    pos_d  = pos_q;
    held_d = held_q;
    if (in_i.char_code > tcp_pkg::HalfWidthMax) begin
      if (pos_q[0]) begin
        run_o.bytes[0] = tcp_pkg::SpaceByte;
        run_o.bytes[1] = tcp_pkg::addr_cmd(pos_q + 6'd1);
        run_o.bytes[2] = code[15:8];
        run_o.bytes[3] = code[7:0];
        run_o.cmd      = 4'b0010;
        run_o.last_idx = 2'd3;
        pos_d          = pos_q + 6'd3;
      end else begin
        run_o.bytes[0] = tcp_pkg::addr_cmd(pos_q);
        run_o.bytes[1] = code[15:8];
        run_o.bytes[2] = code[7:0];
        run_o.cmd      = 4'b0001;
        run_o.last_idx = 2'd2;
        pos_d          = pos_q + 6'd2;
      end
    end else begin
      run_o.bytes[0] = tcp_pkg::addr_cmd(pos_q);
      run_o.cmd      = 4'b0001;
      run_o.last_idx = 2'd2;
      pos_d          = pos_q + 6'd1;
      if (pos_q[0]) begin
        run_o.bytes[1] = held_q;
        run_o.bytes[2] = lo_b;
      end else begin
        run_o.bytes[1] = lo_b;
        run_o.bytes[2] = tcp_pkg::SpaceByte;
        held_d         = lo_b;
      end
    end
    if (in_i.req_type == tcp_pkg::ReqCursor) begin
      pos_d  = {in_i.cursor_row, in_i.cursor_column};
      held_d = held_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      held_q <= '0;
    end else if (accept) begin
      pos_q  <= pos_d;
      held_q <= held_d;
    end
  end

endmodule

### src/tcp_queue.sv
// Short FIFO of word runs between the front end and the back end.
module tcp_queue #(
  parameter int unsigned Depth = tcp_pkg::QueueDepthDef   // 2 or more
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tcp_pkg::run_t run_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output tcp_pkg::run_t run_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  tcp_pkg::run_t       mem_q [Depth];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [CntW-1:0]     cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign run_o   = mem_q[rd_q];

  function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] p);
    inc = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= run_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= inc(wr_q);
      if (pop_i)  rd_q <= inc(rd_q);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("run queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o))
    else $error("run queue read while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("run queue count out of range");

endmodule

### src/tcp_back.sv
// Back end: walks a run into the output reg one word per unstalled cycle.
module tcp_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  tcp_pkg::run_t run_i,
  output logic          pop_o,
  tcp_out_if.source     out_o
);

  logic [1:0]  idx_q;
  logic        valid_q;
  logic        cmd_q, last_q;
  logic [7:0]  byte_q;
  logic        load, is_last;

  assign load    = q_valid_i && (!valid_q || out_o.ready);
  assign is_last = (idx_q == run_i.last_idx);
  assign pop_o   = load && is_last;

  assign out_o.valid        = valid_q;
  assign out_o.is_command   = cmd_q;
  assign out_o.byte_value   = byte_q;
  assign out_o.serial_frame = tcp_pkg::serial_frame(cmd_q, byte_q);
  assign out_o.last_of_run  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= run_i.bytes[idx_q];
      cmd_q  <= run_i.cmd[idx_q];
      last_q <= is_last;
    end
  end

  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid_i |-> idx_q <= run_i.last_idx)
    else $error("word index past end of run");

endmodule

### src/text_cell_placement.sv
// Top level of the text cell placement block: front end, run queue, back end.
// The first word of a run passes through the run queue and then the output word register.
// Throughput: the back end sends one word per cycle while the output is ready, so a
//   place item sends 3 or 4 words (4 for a full-width code on an odd column); set-cursor
//   items are taken at the front and send nothing. The output word register sets the rate.
// Reset (rst_ni low, async): cursor to row 0 column 0, held byte 0, queue empty.
module text_cell_placement #(
  parameter int unsigned QueueDepth = tcp_pkg::QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcp_in_if.sink     in_i,
  tcp_out_if.source  out_o
);

  // Front end pushes one run per place item; full queue stalls input.
  logic          push, q_full, q_valid, pop;
  tcp_pkg::run_t run_in, run_head;

  tcp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .run_o    (run_in)
  );

  // Decouples item intake from word output so each side stalls on its own.
  tcp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .run_i   (run_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .run_o   (run_head)
  );

  // Back end emits the head run word by word; the run pops with its last word.
  tcp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .run_i     (run_head),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule
